FILE: hdl/pvts_pkg.sv
// Shared types, constants and rounding helper for the path vertex transform store.
package pvts_pkg;

   localparam int POINT_DEPTH_DEFAULT = 1024;
   localparam int LOOP_DEPTH_DEFAULT  = 64;

   localparam int COORD_W     = 24;
   localparam int DEV_W       = 16;
   localparam int IDX_W       = 11;
   localparam int LEN_W       = 11;
   localparam int LCOUNT_W    = 7;
   localparam int CSR_IDX_W   = 3;
   localparam int PROD_W      = 2 * COORD_W;
   localparam int ACC_W       = 50;
   localparam int STEP_W      = 4;
   localparam int MUL_STEPS   = 4;
   localparam int QUEUE_DEPTH = 2;

   localparam logic signed [COORD_W-1:0] COEF_A_RESET   = 24'sh01_0000;
   localparam logic signed [COORD_W-1:0] COEF_B_RESET   = 24'sh00_0000;
   localparam logic signed [COORD_W-1:0] COEF_C_RESET   = 24'sh00_0000;
   localparam logic signed [COORD_W-1:0] COEF_D_RESET   = 24'sh01_0000;
   localparam logic signed [COORD_W-1:0] OFFSET_X_RESET = 24'sh00_0000;
   localparam logic signed [COORD_W-1:0] OFFSET_Y_RESET = 24'sh00_0000;

   localparam logic signed [ACC_W-1:0] ROUND_HALF = 50'sh80_0000;

   typedef enum logic [1:0] {
      MODE_ADD   = 2'd0,
      MODE_CLOSE = 2'd1,
      MODE_NEW   = 2'd2,
      MODE_READ  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_DONE       = 3'd0,
      ST_DUPLICATE  = 3'd1,
      ST_STORE_FULL = 3'd2,
      ST_SHORT_LOOP = 3'd3,
      ST_LOOP_FULL  = 3'd4,
      ST_BAD_INDEX  = 3'd5
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_A   = 3'd0,
      CSR_COEF_B   = 3'd1,
      CSR_COEF_C   = 3'd2,
      CSR_COEF_D   = 3'd3,
      CSR_OFFSET_X = 3'd4,
      CSR_OFFSET_Y = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_MUL,
      F_ROUND,
      F_MOD,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_ISSUE,
      B_EVAL_A,
      B_EVAL_B,
      B_RESP
   } back_state_type;

   typedef struct packed {
      logic [1:0]                mode;
      logic signed [COORD_W-1:0] vert_x;
      logic signed [COORD_W-1:0] vert_y;
      logic [IDX_W-1:0]          read_index;
   } req_type;

   typedef struct packed {
      logic [2:0]              status;
      logic signed [DEV_W-1:0] point_x;
      logic signed [DEV_W-1:0] point_y;
      logic [IDX_W-1:0]        point_count;
      logic [LCOUNT_W-1:0]     loop_count;
      logic [LEN_W-1:0]        loop_length;
   } rsp_type;

   // classified request handed from front to back
   typedef struct packed {
      mode_type                mode;
      logic signed [DEV_W-1:0] point_x;
      logic signed [DEV_W-1:0] point_y;
      logic [IDX_W-1:0]        read_index;
      logic [IDX_W-1:0]        loop_index;
   } task_type;

   // 24 fractional bits in, round half up by floor, clamp to int16
   function automatic logic signed [DEV_W-1:0] round_sat(input logic signed [ACC_W-1:0] value);
      logic signed [ACC_W-1:0]  biased;
      logic signed [ACC_W-25:0] whole;
      biased = value + ROUND_HALF;
      whole  = biased[ACC_W-1:24];
      if (whole > 26'sd32767) begin
         return 16'sh7FFF;
      end else if (whole < -26'sd32768) begin
         return -16'sh8000;
      end
      return whole[DEV_W-1:0];
   endfunction

endpackage

FILE: hdl/pvts_front.sv
// Front end: config registers, request intake, shared-multiplier transform, loop index reduce.
module pvts_front #(
   parameter int LOOP_DEPTH = pvts_pkg::LOOP_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  pvts_pkg::req_type             req_data,
   input  logic                          csr_valid,
   input  logic [pvts_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pvts_pkg::COORD_W-1:0]  csr_data,
   output logic                          push,
   output pvts_pkg::task_type            push_task,
   input  logic                          q_full
);
   import pvts_pkg::*;

   // reciprocal of LOOP_DEPTH, exact quotient for every 11-bit index
   localparam int RCP_SHIFT = IDX_W + $clog2(LOOP_DEPTH);
   localparam int RCP_W     = IDX_W + 2;
   localparam int RED_W     = IDX_W + RCP_W;
   localparam int DEP_W     = $clog2(LOOP_DEPTH + 1);
   localparam int BACK_W    = IDX_W + DEP_W;
   localparam logic [RCP_W-1:0] RCP_MUL =
      RCP_W'((2 ** RCP_SHIFT + LOOP_DEPTH - 1) / LOOP_DEPTH);

   front_state_type state_ff, state_in;

   logic signed [COORD_W-1:0] coef_a_ff, coef_b_ff, coef_c_ff, coef_d_ff;
   logic signed [COORD_W-1:0] offset_x_ff, offset_y_ff;

   req_type                   req_ff;
   logic [STEP_W-1:0]         step_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   acc_x_ff, acc_y_ff;
   logic signed [DEV_W-1:0]   px_ff, py_ff;
   logic [IDX_W-1:0]          li_ff;
   logic [IDX_W-1:0]          quo_ff;

   logic signed [COORD_W-1:0] mul_l, mul_r;
   logic signed [ACC_W-1:0]   prod_ext;
   logic [RED_W-1:0]          red_prod;
   logic [BACK_W-1:0]         red_back;
   logic                      req_fire;

   assign req_fire = req_valid && req_ready;
   assign prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   // step 0: quotient by reciprocal multiply; step 1: remainder by multiply-back
   assign red_prod = RED_W'(li_ff) * RED_W'(RCP_MUL);
   assign red_back = BACK_W'(li_ff) - BACK_W'(quo_ff) * BACK_W'(LOOP_DEPTH);

   // one multiplier, four products in turn
   always_comb begin
      case (step_ff)
         STEP_W'(0): begin mul_l = req_ff.vert_x; mul_r = coef_a_ff; end
         STEP_W'(1): begin mul_l = req_ff.vert_y; mul_r = coef_c_ff; end
         STEP_W'(2): begin mul_l = req_ff.vert_x; mul_r = coef_b_ff; end
         default:    begin mul_l = req_ff.vert_y; mul_r = coef_d_ff; end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               case (req_data.mode)
                  MODE_ADD:  state_in = F_MUL;
                  MODE_READ: state_in = F_MOD;
                  default:   state_in = F_PUSH;
               endcase
            end
         end
         F_MUL: begin
            if (step_ff == STEP_W'(MUL_STEPS)) state_in = F_ROUND;
         end
         F_ROUND: state_in = F_PUSH;
         F_MOD: begin
            if (step_ff == STEP_W'(1)) state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!q_full) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_comb begin
      req_ready            = (state_ff == F_IDLE);
      push                 = (state_ff == F_PUSH) && !q_full;
      push_task.mode       = mode_type'(req_ff.mode);
      push_task.point_x    = px_ff;
      push_task.point_y    = py_ff;
      push_task.read_index = req_ff.read_index;
      push_task.loop_index = li_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= F_IDLE;
         step_ff     <= '0;
         coef_a_ff   <= COEF_A_RESET;
         coef_b_ff   <= COEF_B_RESET;
         coef_c_ff   <= COEF_C_RESET;
         coef_d_ff   <= COEF_D_RESET;
         offset_x_ff <= OFFSET_X_RESET;
         offset_y_ff <= OFFSET_Y_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_COEF_A:   coef_a_ff   <= csr_data;
               CSR_COEF_B:   coef_b_ff   <= csr_data;
               CSR_COEF_C:   coef_c_ff   <= csr_data;
               CSR_COEF_D:   coef_d_ff   <= csr_data;
               CSR_OFFSET_X: offset_x_ff <= csr_data;
               CSR_OFFSET_Y: offset_y_ff <= csr_data;
               default: ;
            endcase
         end
         if (req_fire) begin
            step_ff <= '0;
         end else if (state_ff == F_MUL || state_ff == F_MOD) begin
            step_ff <= step_ff + STEP_W'(1);
         end
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff   <= req_data;
         li_ff    <= req_data.read_index;
         acc_x_ff <= {{(ACC_W-COORD_W-16){offset_x_ff[COORD_W-1]}}, offset_x_ff, 16'b0};
         acc_y_ff <= {{(ACC_W-COORD_W-16){offset_y_ff[COORD_W-1]}}, offset_y_ff, 16'b0};
      end
      case (state_ff)
         F_MUL: begin
            prod_ff <= mul_l * mul_r;
            if (step_ff == STEP_W'(1) || step_ff == STEP_W'(2)) begin
               acc_x_ff <= acc_x_ff + prod_ext;
            end else if (step_ff != STEP_W'(0)) begin
               acc_y_ff <= acc_y_ff + prod_ext;
            end
         end
         F_ROUND: begin
            px_ff <= round_sat(acc_x_ff);
            py_ff <= round_sat(acc_y_ff);
         end
         F_MOD: begin
            if (step_ff == STEP_W'(0)) begin
               quo_ff <= IDX_W'(red_prod >> RCP_SHIFT);
            end else begin
               li_ff <= IDX_W'(red_back);
            end
         end
         default: ;
      endcase
   end

endmodule

FILE: hdl/pvts_queue.sv
// Small register FIFO between front and back.
module pvts_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pvts_pkg::task_type push_task,
   output logic               q_full,
   input  logic               pop,
   output pvts_pkg::task_type pop_task,
   output logic               q_empty
);
   import pvts_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   task_type           entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
   endfunction

   assign q_full   = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_empty  = (count_ff == '0);
   assign pop_task = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= next_ptr(wr_ptr_ff);
         if (pop)  rd_ptr_ff <= next_ptr(rd_ptr_ff);
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) entries_ff[wr_ptr_ff] <= push_task;
   end

endmodule

FILE: hdl/pvts_back.sv
// Back end: path state, point and loop memories, execution sequencer, response register.
module pvts_back #(
   parameter int POINT_DEPTH = pvts_pkg::POINT_DEPTH_DEFAULT,
   parameter int LOOP_DEPTH  = pvts_pkg::LOOP_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   output logic               pop,
   input  pvts_pkg::task_type pop_task,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output pvts_pkg::rsp_type  rsp_data
);
   import pvts_pkg::*;

   localparam int CNT_W   = $clog2(POINT_DEPTH + 2);
   localparam int CNT1_W  = CNT_W + 1;
   localparam int PADDR_W = $clog2(POINT_DEPTH + 1);
   localparam int LCNT_W  = $clog2(LOOP_DEPTH + 1);
   localparam int LIDX_W  = $clog2(LOOP_DEPTH);
   localparam int CMP_W   = (CNT_W > IDX_W) ? CNT_W : IDX_W;
   localparam int LCMP_W  = (LCNT_W > IDX_W) ? LCNT_W : IDX_W;
   localparam int PT_W    = 2 * DEV_W;

   back_state_type state_ff, state_in;

   task_type                task_ff;
   logic [CNT_W-1:0]        points_held_ff, start_ff, last_len_ff;
   logic [LCNT_W-1:0]       loops_held_ff;
   logic [PT_W-1:0]         first_pt_ff;
   status_type              res_status_ff;
   logic signed [DEV_W-1:0] res_x_ff, res_y_ff;
   logic [CNT_W-1:0]        res_len_ff;
   logic                    res_read_len_ff;
   rsp_type                 rsp_ff;
   logic                    rsp_valid_ff;

   logic [PT_W-1:0]         pt_mem [POINT_DEPTH + 1];
   logic [CNT_W-1:0]        lp_mem [LOOP_DEPTH];
   logic [PT_W-1:0]         pt_rd_data_ff;
   logic [CNT_W-1:0]        lp_rd_data_ff;

   logic                    pt_rd_en, pt_wr_en, lp_rd_en, lp_wr_en;
   logic [PADDR_W-1:0]      pt_rd_addr, pt_wr_addr;
   logic [PT_W-1:0]         pt_wr_data;
   logic [LIDX_W-1:0]       lp_rd_addr, lp_wr_addr;
   logic [CNT_W-1:0]        lp_wr_data;

   logic [PADDR_W-1:0]      last_addr;
   logic [PT_W-1:0]         cur_pt;
   logic                    loop_ok, table_full, dup, store_full, idx_ok, li_ok;
   logic                    append_close, slot_free;
   logic [CNT_W-1:0]        close_count;
   rsp_type                 rsp_build;

   assign last_addr    = PADDR_W'(points_held_ff - CNT_W'(1));
   assign cur_pt       = {task_ff.point_x, task_ff.point_y};
   assign loop_ok      = CNT1_W'(points_held_ff) > (CNT1_W'(start_ff) + CNT1_W'(2));
   assign table_full   = loops_held_ff >= LCNT_W'(LOOP_DEPTH);
   assign dup          = (points_held_ff != '0) && (pt_rd_data_ff == cur_pt);
   assign store_full   = points_held_ff >= CNT_W'(POINT_DEPTH);
   assign idx_ok       = CMP_W'(task_ff.read_index) < CMP_W'(points_held_ff);
   assign li_ok        = LCMP_W'(task_ff.loop_index) < LCMP_W'(loops_held_ff);
   assign append_close = (pt_rd_data_ff != first_pt_ff) &&
                         (points_held_ff <= CNT_W'(POINT_DEPTH));
   assign close_count  = append_close ? points_held_ff + CNT_W'(1) : points_held_ff;
   assign slot_free    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

   always_comb begin
      rsp_build.status      = res_status_ff;
      rsp_build.point_x     = res_x_ff;
      rsp_build.point_y     = res_y_ff;
      rsp_build.point_count = IDX_W'(points_held_ff);
      rsp_build.loop_count  = LCOUNT_W'(loops_held_ff);
      if (res_read_len_ff) begin
         rsp_build.loop_length = LEN_W'(res_len_ff);
      end else if (loops_held_ff == '0) begin
         rsp_build.loop_length = '0;
      end else begin
         rsp_build.loop_length = LEN_W'(last_len_ff);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (!q_empty) state_in = B_ISSUE;
         end
         B_ISSUE: begin
            case (task_ff.mode)
               MODE_CLOSE: state_in = (loop_ok && !table_full) ? B_EVAL_A : B_RESP;
               MODE_NEW:   state_in = B_RESP;
               default:    state_in = B_EVAL_A;
            endcase
         end
         B_EVAL_A: state_in = (task_ff.mode == MODE_CLOSE) ? B_EVAL_B : B_RESP;
         B_EVAL_B: state_in = B_RESP;
         B_RESP: begin
            if (slot_free) state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      pop        = 1'b0;
      pt_rd_en   = 1'b0;
      pt_rd_addr = last_addr;
      pt_wr_en   = 1'b0;
      pt_wr_addr = PADDR_W'(points_held_ff);
      pt_wr_data = cur_pt;
      lp_rd_en   = 1'b0;
      lp_rd_addr = LIDX_W'(task_ff.loop_index);
      lp_wr_en   = 1'b0;
      lp_wr_addr = LIDX_W'(loops_held_ff);
      lp_wr_data = close_count - start_ff;
      case (state_ff)
         B_IDLE: pop = !q_empty;
         B_ISSUE: begin
            case (task_ff.mode)
               MODE_ADD: pt_rd_en = 1'b1;
               MODE_CLOSE: begin
                  pt_rd_en   = loop_ok && !table_full;
                  pt_rd_addr = PADDR_W'(start_ff);
               end
               MODE_READ: begin
                  pt_rd_en   = 1'b1;
                  pt_rd_addr = PADDR_W'(task_ff.read_index);
                  lp_rd_en   = 1'b1;
               end
               default: ;
            endcase
         end
         B_EVAL_A: begin
            case (task_ff.mode)
               MODE_ADD:   pt_wr_en = !dup && !store_full;
               MODE_CLOSE: pt_rd_en = 1'b1;
               default: ;
            endcase
         end
         B_EVAL_B: begin
            pt_wr_en   = append_close;
            pt_wr_data = first_pt_ff;
            lp_wr_en   = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= B_IDLE;
         points_held_ff <= '0;
         start_ff       <= '0;
         loops_held_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            B_ISSUE: begin
               case (task_ff.mode)
                  MODE_CLOSE: begin
                     if (!loop_ok) points_held_ff <= start_ff;
                  end
                  MODE_NEW: begin
                     points_held_ff <= '0;
                     start_ff       <= '0;
                     loops_held_ff  <= '0;
                  end
                  default: ;
               endcase
            end
            B_EVAL_A: begin
               if (task_ff.mode == MODE_ADD && !dup && !store_full) begin
                  points_held_ff <= points_held_ff + CNT_W'(1);
               end
            end
            B_EVAL_B: begin
               points_held_ff <= close_count;
               start_ff       <= close_count;
               loops_held_ff  <= loops_held_ff + LCNT_W'(1);
            end
            default: ;
         endcase
         if (state_ff == B_RESP && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload side
   always_ff @(posedge clock) begin
      if (pop) task_ff <= pop_task;
      case (state_ff)
         B_ISSUE: begin
            res_status_ff   <= ST_DONE;
            res_x_ff        <= '0;
            res_y_ff        <= '0;
            res_read_len_ff <= 1'b0;
            if (task_ff.mode == MODE_CLOSE) begin
               if (!loop_ok) begin
                  if (points_held_ff > start_ff) res_status_ff <= ST_SHORT_LOOP;
               end else if (table_full) begin
                  res_status_ff <= ST_LOOP_FULL;
               end
            end
         end
         B_EVAL_A: begin
            case (task_ff.mode)
               MODE_ADD: begin
                  res_x_ff <= task_ff.point_x;
                  res_y_ff <= task_ff.point_y;
                  if (dup) begin
                     res_status_ff <= ST_DUPLICATE;
                  end else if (store_full) begin
                     res_status_ff <= ST_STORE_FULL;
                  end
               end
               MODE_CLOSE: first_pt_ff <= pt_rd_data_ff;
               MODE_READ: begin
                  res_read_len_ff <= 1'b1;
                  res_len_ff      <= li_ok ? lp_rd_data_ff : '0;
                  if (idx_ok) begin
                     res_x_ff <= pt_rd_data_ff[PT_W-1:DEV_W];
                     res_y_ff <= pt_rd_data_ff[DEV_W-1:0];
                  end else begin
                     res_status_ff <= ST_BAD_INDEX;
                  end
               end
               default: ;
            endcase
         end
         B_EVAL_B: begin
            last_len_ff <= close_count - start_ff;
            res_x_ff    <= first_pt_ff[PT_W-1:DEV_W];
            res_y_ff    <= first_pt_ff[DEV_W-1:0];
         end
         B_RESP: begin
            if (slot_free) rsp_ff <= rsp_build;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (pt_wr_en) pt_mem[pt_wr_addr] <= pt_wr_data;
      if (pt_rd_en) pt_rd_data_ff <= pt_mem[pt_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (lp_wr_en) lp_mem[lp_wr_addr] <= lp_wr_data;
      if (lp_rd_en) lp_rd_data_ff <= lp_mem[lp_rd_addr];
   end

   a_points_bound: assert property (@(posedge clock) disable iff (reset)
      points_held_ff <= CNT_W'(POINT_DEPTH + 1))
      else $error("point count beyond store depth");

   a_start_bound: assert property (@(posedge clock) disable iff (reset)
      start_ff <= points_held_ff)
      else $error("open loop starts past the stored points");

   a_loops_bound: assert property (@(posedge clock) disable iff (reset)
      loops_held_ff <= LCNT_W'(LOOP_DEPTH))
      else $error("loop count beyond loop table depth");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == B_RESP))
      else $error("response raised outside the response step");

endmodule

FILE: hdl/path_vertex_transform_store_unit.sv
// Top level of the path vertex transform store: front, queue and back wired together.
//
// Builds polygon paths from a request stream. An add request maps a signed
// Q16.8 vertex through the 2-D affine matrix (Q8.16 terms plus a Q16.8
// offset), rounds half up and clamps to a signed 16-bit device point, and
// appends it unless it repeats the last stored point or the store is full.
// Close seals the open loop (three or more points, first point appended
// when it differs from the last), new-path clears all counts, and read
// returns a stored point and a loop length. Every request yields exactly
// one response. The front end accepts one request at a time: an add holds
// it through one shared 24x24 multiplier run over four products, an
// accumulate drain, a rounding step and the hand-off; a read reduces its
// loop index modulo LOOP_DEPTH in two steps (quotient by reciprocal
// multiply, then multiply back and subtract) before the hand-off, and
// close and new-path go straight to it. The back end (one point-memory
// port, one access per step; a close needs two reads, new-path and a
// close that records nothing need none) is overlapped with the front
// through a two-entry queue, so for adds the front sets the sustained
// rate. The response sits in an output register and does not block the
// next request. The point and loop memories are not cleared; counts
// guard every read. Configuration writes are always taken (csr_ready
// is tied high) and must only be made while no request is in flight.
module path_vertex_transform_store_unit #(
   parameter int POINT_DEPTH = pvts_pkg::POINT_DEPTH_DEFAULT,
   parameter int LOOP_DEPTH  = pvts_pkg::LOOP_DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  pvts_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output pvts_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [pvts_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pvts_pkg::COORD_W-1:0]   csr_data
);
   import pvts_pkg::*;

   // front to queue
   logic     push, q_full;
   task_type push_task;
   // queue to back
   logic     pop, q_empty;
   task_type pop_task;

   // register writes never stall
   assign csr_ready = 1'b1;

   pvts_front #(
      .LOOP_DEPTH (LOOP_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .push      (push),
      .push_task (push_task),
      .q_full    (q_full)
   );

   pvts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_task (push_task),
      .q_full    (q_full),
      .pop       (pop),
      .pop_task  (pop_task),
      .q_empty   (q_empty)
   );

   pvts_back #(
      .POINT_DEPTH (POINT_DEPTH),
      .LOOP_DEPTH  (LOOP_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .pop       (pop),
      .pop_task  (pop_task),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
